/* src/ttb_pkg.sv */
// ----------------------------------------------------------------------------
// ttb_pkg
// Shared constants and types of the transition table builder.
// ----------------------------------------------------------------------------
package ttb_pkg;

  // Table geometry
  localparam int unsigned TABLE_DEPTH = 1024;
  localparam int unsigned DEPTH_W     = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W       = DEPTH_W + 1;

  // Field widths
  localparam int unsigned CODE_W  = 16;
  localparam int unsigned EVENT_W = 16;
  localparam int unsigned KEY_W   = CODE_W + EVENT_W;

  // Result status codes
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  // Port control of the table store
  typedef struct packed {
    logic               rd_en;
    logic [DEPTH_W-1:0] rd_addr;
    logic               wr_en;
    logic [DEPTH_W-1:0] wr_addr;
  } probe_ctl_t;

endpackage

/* src/transition_table_builder_unit.sv */
// ----------------------------------------------------------------------------
// transition_table_builder_unit
// Prefix-tree insertion: follows or inserts one (code, event) transition per
// command and reports it on a one-cycle result strobe.
// ----------------------------------------------------------------------------
//  Channel  | Transfer when             | Ports
//  ---------+---------------------------+--------------------------------------
//  command  | start & !busy at clk edge | event_id_i, final_code_i, last_event_i
//  result   | result_valid_o at edge    | from_code_o, via_event_o, to_code_o,
//           |                           | is_new_entry_o, status_o
//
// The table is scanned one entry per cycle through the single read port of
// the store, up to the last filled entry on a miss; a hit ends the scan early.
// The compare works on the registered read of each entry, and the result is
// registered once more before its strobe. busy is high while the scan runs; a
// new start may be given in the cycle of the strobe.
// Reset clears the fill count, current code and control and sets the fresh
// code to 1; the store needs no clearing as only filled entries are read.
// The receiver cannot stall: each result is present for one cycle only.
// ----------------------------------------------------------------------------
module transition_table_builder_unit import ttb_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [EVENT_W-1:0] event_id_i,
  input  logic [CODE_W-1:0]  final_code_i,
  input  logic               last_event_i,
  output logic               result_valid_o,
  output logic [CODE_W-1:0]  from_code_o,
  output logic [EVENT_W-1:0] via_event_o,
  output logic [CODE_W-1:0]  to_code_o,
  output logic               is_new_entry_o,
  output logic               status_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic               state_q, state_d;
  logic [CNT_W-1:0]   used_q, used_d;
  logic [CNT_W-1:0]   issue_q, issue_d;
  logic               rd_vld_q, rd_vld_d;
  logic               rd_last_q, rd_last_d;
  logic [CODE_W-1:0]  cur_q, cur_d;
  logic [CODE_W-1:0]  fresh_q, fresh_d;
  logic [EVENT_W-1:0] ev_q;
  logic [CODE_W-1:0]  fin_q;
  logic               last_q;
  logic               res_vld_q, res_vld_d;
  logic [CODE_W-1:0]  res_to_q, res_to_d;
  logic               res_new_q, res_new_d;
  logic               res_st_q, res_st_d;

  probe_ctl_t         ctl;
  logic [KEY_W-1:0]   key;
  logic [CODE_W-1:0]  wr_next;
  logic               match;
  logic [CODE_W-1:0]  rd_next;
  logic               accept;
  logic               hit;
  logic               miss;

  assign accept = start & ~busy;
  assign busy   = (state_q == ST_SCAN);
  assign key    = {cur_q, ev_q};

  // Shared table store and key comparator
  ttb_probe u_probe (
    .clk_i     (clk_i),
    .ctl_i     (ctl),
    .wr_key_i  (key),
    .wr_next_i (wr_next),
    .key_i     (key),
    .match_o   (match),
    .rd_next_o (rd_next)
  );

  // Resolve the scan: hit on a matching entry, miss once the last one fails
  assign hit  = (state_q == ST_SCAN) & rd_vld_q & match;
  assign miss = (state_q == ST_SCAN) & ~hit &
                ((used_q == '0) | (rd_vld_q & rd_last_q));

  assign wr_next = last_q ? fin_q : fresh_q;

  // Sequencer
  always_comb begin
    state_d   = state_q;
    used_d    = used_q;
    issue_d   = issue_q;
    cur_d     = cur_q;
    fresh_d   = fresh_q;
    res_vld_d = 1'b0;
    res_to_d  = res_to_q;
    res_new_d = res_new_q;
    res_st_d  = res_st_q;
    rd_vld_d  = 1'b0;
    rd_last_d = (issue_q == used_q - CNT_W'(1));

    ctl.rd_en   = 1'b0;
    ctl.rd_addr = issue_q[DEPTH_W-1:0];
    ctl.wr_en   = 1'b0;
    ctl.wr_addr = used_q[DEPTH_W-1:0];

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_SCAN;
          issue_d = '0;
        end
      end
      ST_SCAN: begin
        // Advance the scan, one entry per cycle
        if (issue_q < used_q) begin
          ctl.rd_en = 1'b1;
          rd_vld_d  = 1'b1;
          issue_d   = issue_q + CNT_W'(1);
        end
        if (hit) begin
          state_d   = ST_IDLE;
          res_vld_d = 1'b1;
          res_to_d  = rd_next;
          res_new_d = 1'b0;
          res_st_d  = STATUS_OK;
          cur_d     = last_q ? '0 : rd_next;
        end else if (miss) begin
          state_d   = ST_IDLE;
          res_vld_d = 1'b1;
          if (used_q < CNT_W'(TABLE_DEPTH)) begin
            // Insert the new transition at the fill point
            ctl.wr_en = 1'b1;
            used_d    = used_q + CNT_W'(1);
            res_to_d  = wr_next;
            res_new_d = 1'b1;
            res_st_d  = STATUS_OK;
            cur_d     = last_q ? '0 : wr_next;
            if (!last_q) begin
              fresh_d = fresh_q + CODE_W'(1);
            end
          end else begin
            // Table full: drop the miss and restart from the root
            res_to_d  = '0;
            res_new_d = 1'b0;
            res_st_d  = STATUS_FULL;
            cur_d     = '0;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      used_q    <= '0;
      issue_q   <= '0;
      rd_vld_q  <= 1'b0;
      rd_last_q <= 1'b0;
      cur_q     <= '0;
      fresh_q   <= CODE_W'(1);
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      used_q    <= used_d;
      issue_q   <= issue_d;
      rd_vld_q  <= rd_vld_d;
      rd_last_q <= rd_last_d;
      cur_q     <= cur_d;
      fresh_q   <= fresh_d;
      res_vld_q <= res_vld_d;
    end
  end

  // Hold the command fields for the scan
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ev_q   <= event_id_i;
      fin_q  <= final_code_i;
      last_q <= last_event_i;
    end
  end

  // Result payload; from_code is the code before the update
  logic [CODE_W-1:0] res_from_q;
  always_ff @(posedge clk_i) begin
    res_to_q  <= res_to_d;
    res_new_q <= res_new_d;
    res_st_q  <= res_st_d;
    if (hit | miss) begin
      res_from_q <= cur_q;
    end
  end

  assign result_valid_o = res_vld_q;
  assign from_code_o    = res_from_q;
  assign via_event_o    = ev_q;
  assign to_code_o      = res_to_q;
  assign is_new_entry_o = res_new_q;
  assign status_o       = res_st_q;

endmodule

/* src/ttb_probe.sv */
// ----------------------------------------------------------------------------
// ttb_probe
// Transition table store with one write and one read port, and the shared
// key comparator that checks the registered read entry against the search key.
// ----------------------------------------------------------------------------
module ttb_probe import ttb_pkg::*; (
  input  logic              clk_i,
  input  probe_ctl_t        ctl_i,
  input  logic [KEY_W-1:0]  wr_key_i,
  input  logic [CODE_W-1:0] wr_next_i,
  input  logic [KEY_W-1:0]  key_i,
  output logic              match_o,
  output logic [CODE_W-1:0] rd_next_o
);

  logic [KEY_W-1:0]  key_mem  [TABLE_DEPTH];
  logic [CODE_W-1:0] next_mem [TABLE_DEPTH];
  logic [KEY_W-1:0]  rd_key_q;
  logic [CODE_W-1:0] rd_next_q;

  // Write one entry
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      key_mem[ctl_i.wr_addr]  <= wr_key_i;
      next_mem[ctl_i.wr_addr] <= wr_next_i;
    end
  end

  // Read one entry, registered
  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      rd_key_q  <= key_mem[ctl_i.rd_addr];
      rd_next_q <= next_mem[ctl_i.rd_addr];
    end
  end

  // Compare the fetched key
  assign match_o   = (rd_key_q == key_i);
  assign rd_next_o = rd_next_q;

endmodule
